// ===== hw/rtl/aup_pkg.sv =====
package aup_pkg;

  // Channel and dividend widths
  localparam int CHAN_W    = 8;
  localparam int DIVD_W    = 16;
  localparam int NUM_CHAN  = 3;

  // Divider split: 16 quotient bits, 4 per pipeline stage
  localparam int STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES      = DIVD_W / STEPS_PER_STAGE;

  // Channel slots inside a stage word
  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;

  // Pixel byte positions
  localparam int ALPHA_LSB = 24;
  localparam int RED_LSB   = 16;
  localparam int GREEN_LSB = 8;
  localparam int BLUE_LSB  = 0;

  // One channel of the restoring divider: partial remainder plus a word that
  // holds the dividend bits still to go (top) and the quotient bits so far (bottom)
  typedef struct packed {
    logic [CHAN_W-1:0] rem;
    logic [DIVD_W-1:0] dq;
  } aup_chan_t;

  // One pipeline stage word
  typedef struct packed {
    logic [CHAN_W-1:0]                alpha;
    aup_chan_t [NUM_CHAN-1:0]         chan;
  } aup_stage_t;

endpackage

// ===== hw/rtl/aup_div_stage.sv =====
module aup_div_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                valid_in,
  input  aup_pkg::aup_stage_t data_in,
  output logic                valid_out,
  output aup_pkg::aup_stage_t data_out
);
  import aup_pkg::*;

  logic       v_r;
  aup_stage_t d_r;
  aup_stage_t d_nxt;

  // Four restoring division steps per channel
  always_comb begin
    logic [CHAN_W:0]   sh;
    logic [CHAN_W-1:0] rem;
    logic [DIVD_W-1:0] dq;
    d_nxt = data_in;
    for (int c = 0; c < NUM_CHAN; c++) begin
      rem = data_in.chan[c].rem;
      dq  = data_in.chan[c].dq;
      for (int s = 0; s < STEPS_PER_STAGE; s++) begin
        sh = {rem, dq[DIVD_W-1]};
        dq = {dq[DIVD_W-2:0], 1'b0};
        if (sh >= {1'b0, data_in.alpha}) begin
          rem   = CHAN_W'(sh - {1'b0, data_in.alpha});
          dq[0] = 1'b1;
        end else begin
          rem = sh[CHAN_W-1:0];
        end
      end
      d_nxt.chan[c].rem = rem;
      d_nxt.chan[c].dq  = dq;
    end
  end

  // Stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= valid_in;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (en && valid_in) begin
      d_r <= d_nxt;
    end
  end

  assign valid_out = v_r;
  assign data_out  = d_r;

endmodule

// ===== hw/rtl/alpha_unpremultiply_pixel.sv =====
// Straight-alpha conversion of premultiplied ARGB32 pixels.
//
// Input channel: in_valid / in_ready carry one request, in_pixel, with alpha
// in bits 31..24 and red, green, blue below it. Result channel: out_valid /
// out_ready carry out_red, out_green, out_blue and out_alpha. Each colour is
// (c*255 + alpha/2) / alpha rounded, low 8 bits kept; zero alpha gives zero
// colours. Alpha passes through.
//
// One stage forms the dividends, then four stages of a restoring divider retire
// four quotient bits each for all three channels at once. One pixel is accepted
// every cycle unless a stalled receiver has filled every stage; pixels are
// independent.
//
// Reset clears every stage valid bit; in_ready is high right after reset.
// When the receiver holds out_ready low the last stage keeps its result and
// the stages behind it fill their empty slots, so in_ready drops only once
// every stage holds a pixel. No pixel is lost or repeated.
module alpha_unpremultiply_pixel (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha
);
  import aup_pkg::*;

  logic                pre_v_r;
  aup_stage_t          pre_r;
  aup_stage_t          pre_nxt;
  logic [DIV_STAGES:0] stg_v;
  logic [DIV_STAGES:0] stg_en;
  aup_stage_t          stg_d [0:DIV_STAGES];
  aup_stage_t          last_d;
  logic [CHAN_W-1:0]   a_in;
  logic [CHAN_W-1:0]   c_in [NUM_CHAN];
  logic                zero_a;

  // Stage enables: a stage loads when empty or when the next one moves
  always_comb begin
    stg_en[DIV_STAGES] = !stg_v[DIV_STAGES] || out_ready;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      stg_en[k] = !stg_v[k] || stg_en[k+1];
    end
  end

  assign in_ready = stg_en[0];

  // Dividend prep: c*255 + alpha/2, remainder starts at zero
  assign a_in           = in_pixel[ALPHA_LSB +: CHAN_W];
  assign c_in[CH_RED]   = in_pixel[RED_LSB +: CHAN_W];
  assign c_in[CH_GREEN] = in_pixel[GREEN_LSB +: CHAN_W];
  assign c_in[CH_BLUE]  = in_pixel[BLUE_LSB +: CHAN_W];

  always_comb begin
    pre_nxt.alpha = a_in;
    for (int c = 0; c < NUM_CHAN; c++) begin
      pre_nxt.chan[c].rem = '0;
      pre_nxt.chan[c].dq  = {c_in[c], {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, c_in[c]}
                            + {{(CHAN_W+1){1'b0}}, a_in[CHAN_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_v_r <= 1'b0;
    end else if (stg_en[0]) begin
      pre_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[0] && in_valid) begin
      pre_r <= pre_nxt;
    end
  end

  assign stg_v[0] = pre_v_r;
  assign stg_d[0] = pre_r;

  // Divider stages
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    aup_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (stg_en[k+1]),
      .valid_in  (stg_v[k]),
      .data_in   (stg_d[k]),
      .valid_out (stg_v[k+1]),
      .data_out  (stg_d[k+1])
    );
  end

  // Output: low quotient byte, forced to zero for zero alpha
  assign last_d    = stg_d[DIV_STAGES];
  assign zero_a    = (last_d.alpha == '0);
  assign out_valid = stg_v[DIV_STAGES];
  assign out_alpha = last_d.alpha;
  assign out_red   = zero_a ? '0 : last_d.chan[CH_RED].dq[CHAN_W-1:0];
  assign out_green = zero_a ? '0 : last_d.chan[CH_GREEN].dq[CHAN_W-1:0];
  assign out_blue  = zero_a ? '0 : last_d.chan[CH_BLUE].dq[CHAN_W-1:0];

  // Zero alpha never yields a colour
  a_zero_alpha : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alpha == '0 |-> out_red == '0 && out_green == '0 && out_blue == '0)
    else $error("nonzero colour with zero alpha");

  // An empty output stage never blocks the input
  a_empty_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  // A draining receiver lets the whole pipeline advance
  a_flow : assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // Final remainder is below the divisor
  a_rem_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !zero_a |-> last_d.chan[CH_RED].rem < last_d.alpha
      && last_d.chan[CH_GREEN].rem < last_d.alpha
      && last_d.chan[CH_BLUE].rem < last_d.alpha)
    else $error("divider remainder out of range");

endmodule

// ===== test/straight_alpha_check_pkg.sv =====
package straight_alpha_check_pkg;

  import aup_pkg::*;

  // One straight-alpha pixel as the block should return it
  typedef struct {
    logic [31:0]       pixel;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } straight_px_t;

  class straight_alpha_checker;

    straight_px_t straight_q[$];
    int           n_fail;
    int           n_mismatch;

    function new();
      n_fail     = 0;
      n_mismatch = 0;
    endfunction

    // Rounded c*255/a, low byte kept; zero alpha gives zero
    static function logic [CHAN_W-1:0] unpremul_chan(logic [CHAN_W-1:0] c,
                                                     logic [CHAN_W-1:0] a);
      logic [31:0] num;
      logic [31:0] quo;
      if (a == '0) return '0;
      num = 32'(c) * 32'd255 + 32'(a >> 1);
      quo = num / 32'(a);
      return quo[CHAN_W-1:0];
    endfunction

    static function straight_px_t unpremul_pixel(logic [31:0] px);
      straight_px_t s;
      logic [CHAN_W-1:0] a;
      a       = px[ALPHA_LSB +: CHAN_W];
      s.pixel = px;
      s.alpha = a;
      s.red   = unpremul_chan(px[RED_LSB   +: CHAN_W], a);
      s.green = unpremul_chan(px[GREEN_LSB +: CHAN_W], a);
      s.blue  = unpremul_chan(px[BLUE_LSB  +: CHAN_W], a);
      return s;
    endfunction

    // Accepted input request: queue what it must turn into
    function void note_pixel(logic [31:0] px);
      straight_q.push_back(unpremul_pixel(px));
    endfunction

    function void report(string msg);
      n_fail++;
      n_mismatch++;
      if (n_mismatch <= 10) $display("%s", msg);
    endfunction

    // Accepted result: compare with the oldest expectation
    function void check_result(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                               logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] a);
      straight_px_t s;
      if (straight_q.size() == 0) begin
        report($sformatf("unexpected result r=%02h g=%02h b=%02h a=%02h", r, g, b, a));
        return;
      end
      s = straight_q.pop_front();
      if (r !== s.red || g !== s.green || b !== s.blue || a !== s.alpha)
        report($sformatf(
          "mismatch pixel %08h: expected r=%02h g=%02h b=%02h a=%02h, got r=%02h g=%02h b=%02h a=%02h",
          s.pixel, s.red, s.green, s.blue, s.alpha, r, g, b, a));
    endfunction

    function int pending();
      return straight_q.size();
    endfunction

    // Anything left over at the end never came out
    function void check_drained();
      if (straight_q.size() != 0)
        report($sformatf("%0d results never arrived, oldest pixel %08h",
                         straight_q.size(), straight_q[0].pixel));
    endfunction

  endclass

endpackage

// ===== test/tb_alpha_unpremultiply_pixel.sv =====
module tb_alpha_unpremultiply_pixel;

  timeunit 1ns;
  timeprecision 1ps;

  import aup_pkg::*;
  import straight_alpha_check_pkg::*;

  localparam int ITEMS_PER_PHASE = 550;

  // Extremes, zero alpha, rounding, colour above alpha
  localparam logic [31:0] DIRECTED [22] = '{
    32'h0000_0000, 32'h00ff_ffff, 32'h0012_3456, 32'hffff_ffff,
    32'hff00_0000, 32'hff12_3456, 32'h0101_0101, 32'h01ff_ffff,
    32'h0100_0000, 32'h0180_0001, 32'h0201_0101, 32'h0202_0100,
    32'h8080_8080, 32'h807f_7f7f, 32'h80ff_0000, 32'h0301_0203,
    32'h7f3f_3f40, 32'hfe7f_7f7f, 32'hff80_0001, 32'h55aa_55aa,
    32'haa55_aa55, 32'hfffe_fdfc
  };

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [31:0] in_pixel  = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;

  // Idle rates in percent
  int snd_idle = 21;
  int rcv_idle = 64;

  straight_alpha_checker sb = new();

  alpha_unpremultiply_pixel dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pixel  (in_pixel),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  // Watch both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_pixel(in_pixel);
      if (out_valid && out_ready) sb.check_result(out_red, out_green, out_blue, out_alpha);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_pixel(input logic [31:0] px);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Hold off requests until the pipeline has drained
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Mostly well-formed premultiplied pixels, some alpha extremes and raw noise
  function automatic logic [31:0] rand_pixel();
    logic [7:0] a;
    int         kind;
    kind = $urandom_range(9);
    case (kind)
      0: return $urandom();
      1: return {8'h00, 24'($urandom())};
      2: return {8'hff, 24'($urandom())};
      3: begin
        a = 8'($urandom_range(255, 1));
        return {a, a, 8'($urandom_range(a)), a};
      end
      default: begin
        a = 8'($urandom_range(255, 1));
        return {a, 8'($urandom_range(a)), 8'($urandom_range(a)), 8'($urandom_range(a))};
      end
    endcase
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      send_pixel(rand_pixel());
      if (i == n / 2) hold_until_drained();
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i]) send_pixel(DIRECTED[i]);
    run_random(ITEMS_PER_PHASE);

    snd_idle = 64;
    rcv_idle = 21;
    run_random(ITEMS_PER_PHASE);

    snd_idle = 0;
    rcv_idle = 0;
    run_random(ITEMS_PER_PHASE);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    sb.check_drained();

    if (sb.n_fail == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Run limit
  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
